### hw/rtl/assert_macros.svh
// assertion helpers used by the sampler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_AT(label, clk, rst_n, !(expr), msg)

`endif

### hw/rtl/ccis_pkg.sv
package ccis_pkg;

	// fixed field widths and default table depth
	localparam int WEIGHT_W = 32;
	localparam int SUM_W = 42;
	localparam int INDEX_W = 10;
	localparam int MAX_PARTICLES_DEF = 1024;

	// saturation value of the running total
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// request kinds on the input word
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	// control from the top level to the search sequencer
	typedef struct packed {
		logic start;
		logic ack;
	} search_ctrl_t;

endpackage

### hw/rtl/categorical_inverse_cdf_sampler.sv
// Particle resampler: load words (tuser req_type 0) append a Q0.32 weight to a
// prefix-sum RAM, first_weight restarting the table; draw words (req_type 1)
// return the lowest index whose prefix sum is not below the Q0.32 uniform, or
// the last loaded index when u exceeds the total, and index 0 with table_empty
// set when nothing is loaded. A draw does one RAM read and one 42-bit compare
// per probe, in a single shared unit, then writes the result word to the
// output register. A result word still held in the output register adds its
// wait to the next draw's final cycle. The block takes no new word while a
// draw is in flight, including while its result waits for the output register
// to free. The running total saturates at 2^42-1; loads into a full table are
// dropped.
module categorical_inverse_cdf_sampler #(
	parameter int MAX_PARTICLES = ccis_pkg::MAX_PARTICLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // weight [31:0], uniform [63:32]
	input  logic [1:0]  s_tuser,   // req_type [0], first_weight [1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // sample_index [9:0], zero [15:10]
	output logic [0:0]  m_tuser    // table_empty [0]
);

	`include "assert_macros.svh"

	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PARTICLES);

	logic [CNT_W-1:0]                cnt_q;
	logic [ccis_pkg::SUM_W-1:0]      total_q;
	logic                            busy_q;
	logic                            empty_q;
	logic                            m_tvalid_q;
	logic [ccis_pkg::INDEX_W-1:0]    sample_q;
	logic                            table_empty_q;

	logic                            accept;
	logic                            is_draw;
	logic [ccis_pkg::WEIGHT_W-1:0]   weight;
	logic [ccis_pkg::WEIGHT_W-1:0]   uniform;
	logic [CNT_W-1:0]                base_cnt;
	logic [ccis_pkg::SUM_W-1:0]      base_total;
	logic [ccis_pkg::SUM_W:0]        sum_wide;
	logic [ccis_pkg::SUM_W-1:0]      sum_sat;
	logic                            table_full;
	logic                            wr_en;
	logic [CNT_W-1:0]                last_cnt;
	logic [IDX_W-1:0]                hi_init;
	logic                            out_free;
	ccis_pkg::search_ctrl_t          ctrl;
	logic [IDX_W-1:0]                rd_addr;
	logic [ccis_pkg::SUM_W-1:0]      rd_data;
	logic                            search_done;
	logic [IDX_W-1:0]                search_index;

	// input word fields
	assign weight = s_tdata[31:0];
	assign uniform = s_tdata[63:32];
	assign is_draw = (s_tuser[0] == ccis_pkg::REQ_DRAW);
	assign s_tready = !busy_q;
	assign accept = s_tvalid && s_tready;

	// load path: restart, saturating add, append
	always_comb begin
		base_cnt = s_tuser[1] ? '0 : cnt_q;
		base_total = s_tuser[1] ? '0 : total_q;
		sum_wide = {1'b0, base_total}
			+ {{(ccis_pkg::SUM_W + 1 - ccis_pkg::WEIGHT_W){1'b0}}, weight};
		sum_sat = sum_wide[ccis_pkg::SUM_W] ? ccis_pkg::SUM_MAX
			: sum_wide[ccis_pkg::SUM_W-1:0];
		table_full = (base_cnt == CNT_FULL);
		wr_en = accept && !is_draw && !table_full;
	end

	// draw setup: upper search bound is the last loaded index
	assign last_cnt = cnt_q - 1'b1;
	assign hi_init = (cnt_q == '0) ? '0 : last_cnt[IDX_W-1:0];
	assign out_free = !m_tvalid_q || m_tready;
	assign ctrl = '{start: accept && is_draw, ack: search_done && out_free};

	ccis_prefix_ram #(
		.DEPTH (MAX_PARTICLES),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(base_cnt[IDX_W-1:0]),
		.wr_data(sum_sat),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ccis_search #(
		.IDX_W(IDX_W)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.hi_init(hi_init),
		.uniform(uniform),
		.rd_data(rd_data),
		.rd_addr(rd_addr),
		.done   (search_done),
		.index  (search_index)
	);

	// table state, busy flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			total_q <= '0;
			busy_q <= 1'b0;
			empty_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			sample_q <= '0;
			table_empty_q <= 1'b0;
		end else begin
			if (accept && !is_draw) begin
				if (!table_full) begin
					cnt_q <= base_cnt + 1'b1;
					total_q <= sum_sat;
				end else begin
					cnt_q <= base_cnt;
					total_q <= base_total;
				end
			end
			if (ctrl.start) begin
				busy_q <= 1'b1;
				empty_q <= (cnt_q == '0);
			end else if (ctrl.ack) begin
				busy_q <= 1'b0;
			end
			if (ctrl.ack) begin
				m_tvalid_q <= 1'b1;
				sample_q <= ccis_pkg::INDEX_W'(search_index);
				table_empty_q <= empty_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(16 - ccis_pkg::INDEX_W){1'b0}}, sample_q};
	assign m_tuser = table_empty_q;

	// a result word only follows a draw in flight
	`ASSERT_AT(a_result_after_draw, clk, arst_n, $rose(m_tvalid_q) |-> $past(busy_q), "result word without a draw in flight")
	// an empty-table result always carries index zero
	`ASSERT_AT(a_empty_index_zero, clk, arst_n, (m_tvalid_q && table_empty_q) |-> (sample_q == '0), "empty-table result with nonzero index")
	// the table never holds more entries than it has room for
	`ASSERT_NEVER(a_count_bound, clk, arst_n, cnt_q > CNT_FULL, "loaded count beyond table depth")

endmodule

### hw/rtl/ccis_prefix_ram.sv
module ccis_prefix_ram #(
	parameter int DEPTH = ccis_pkg::MAX_PARTICLES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [ccis_pkg::SUM_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [ccis_pkg::SUM_W-1:0] rd_data
);

	logic [ccis_pkg::SUM_W-1:0] mem [DEPTH];
	logic [ccis_pkg::SUM_W-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/ccis_search.sv
module ccis_search #(
	parameter int IDX_W = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ccis_pkg::search_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]              hi_init,
	input  logic [ccis_pkg::WEIGHT_W-1:0] uniform,
	input  logic [ccis_pkg::SUM_W-1:0]    rd_data,
	output logic [IDX_W-1:0]              rd_addr,
	output logic                          done,
	output logic [IDX_W-1:0]              index
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_FINISH
	} state_t;

	state_t                        state_q;
	logic [IDX_W-1:0]              lo_q;
	logic [IDX_W-1:0]              hi_q;
	logic [IDX_W-1:0]              mid_q;
	logic [ccis_pkg::WEIGHT_W-1:0] uniform_q;

	logic                          not_below;
	logic [IDX_W-1:0]              lo_n;
	logic [IDX_W-1:0]              hi_n;
	logic [IDX_W:0]                mid_sum;
	logic [IDX_W-1:0]              mid_n;
	logic [IDX_W-1:0]              mid_init;

	// shared compare of the probed prefix sum against u, then bound update
	always_comb begin
		not_below = rd_data >= {{(ccis_pkg::SUM_W-ccis_pkg::WEIGHT_W){1'b0}}, uniform_q};
		if (not_below) begin
			lo_n = lo_q;
			hi_n = mid_q;
		end else begin
			lo_n = mid_q + 1'b1;
			hi_n = hi_q;
		end
		mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n = mid_sum[IDX_W:1];
		mid_init = hi_init >> 1;
	end

	// first probe address comes straight from the start request
	assign rd_addr = (state_q == S_IDLE) ? mid_init : mid_n;

	// sequencer: one probe per cycle while the bounds differ
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			uniform_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.start) begin
						uniform_q <= uniform;
						lo_q <= '0;
						hi_q <= hi_init;
						mid_q <= mid_init;
						state_q <= (hi_init != '0) ? S_PROBE : S_FINISH;
					end
				end
				S_PROBE: begin
					lo_q <= lo_n;
					hi_q <= hi_n;
					mid_q <= mid_n;
					if (lo_n >= hi_n) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (ctrl.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == S_FINISH);
	assign index = lo_q;

endmodule
